>>> design/sha1bs_pkg.sv
// Shared types, constants and round functions of the SHA-1 byte stream hasher.
package sha1bs_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned Words    = 5;
  localparam int unsigned BlockW   = 512;

  localparam logic [5:0] FillLast  = 6'd63;
  localparam logic [5:0] LenPos    = 6'd56;
  localparam logic [6:0] RoundLast = 7'd79;
  localparam logic [2:0] WordLast  = 3'd4;
  localparam logic [7:0] PadByte   = 8'h80;

  // Index 0 holds H0: the first word of the list lands in the top slot.
  localparam logic [Words-1:0][WordW-1:0] InitValue = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [WordW-1:0] K0 = 32'h5a827999;
  localparam logic [WordW-1:0] K1 = 32'h6ed9eba1;
  localparam logic [WordW-1:0] K2 = 32'h8f1bbcdc;
  localparam logic [WordW-1:0] K3 = 32'hca62c1d6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_ADD,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } state_e;

  // Controls of the shared round unit.
  typedef struct packed {
    logic start;  // load working words from chaining value
    logic step;   // run one round
    logic add;    // fold working words into chaining value
    logic init;   // return chaining value to the initial constants
  } core_ctrl_t;

  function automatic logic [WordW-1:0] round_f(input logic [6:0] rnd,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    logic [WordW-1:0] res;
    if (rnd < 7'd20) begin
      res = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      res = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      res = (b & c) | (b & d) | (c & d);
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [6:0] rnd);
    logic [WordW-1:0] res;
    if (rnd < 7'd20) begin
      res = K0;
    end else if (rnd < 7'd40) begin
      res = K1;
    end else if (rnd < 7'd60) begin
      res = K2;
    end else begin
      res = K3;
    end
    return res;
  endfunction

endpackage

>>> design/sha1bs_sched.sv
// Block buffer and message schedule: a 512-bit shift line loaded by bytes, advanced by words.
module sha1bs_sched (
  input  logic        clk_i,
  input  logic        shift_en_i,
  input  logic [7:0]  shift_byte_i,
  input  logic        advance_i,
  output logic [31:0] w_o
);

  logic [sha1bs_pkg::BlockW-1:0] win_q, win_d;
  logic [31:0]                   mix;
  logic [31:0]                   w_next;

  // Window taps: word 0 is w[t-16], word 2 w[t-14], word 8 w[t-8], word 13 w[t-3].
  assign mix    = win_q[95:64] ^ win_q[255:224] ^ win_q[447:416] ^ win_q[511:480];
  assign w_next = {mix[30:0], mix[31]};
  assign w_o    = win_q[511:480];

  always_comb begin
    win_d = win_q;
    if (advance_i) begin
      win_d = {win_q[479:0], w_next};
    end else if (shift_en_i) begin
      win_d = {win_q[503:0], shift_byte_i};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

>>> design/sha1bs_core_unit.sv
// Shared SHA-1 round unit: working words, round counter and chaining value.
module sha1bs_core_unit (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  sha1bs_pkg::core_ctrl_t                     ctrl_i,
  input  logic [31:0]                                w_i,
  output logic                                       done_o,
  output logic [sha1bs_pkg::Words-1:0][31:0]         chain_o
);

  logic [sha1bs_pkg::Words-1:0][31:0] chain_q, chain_d;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] a_d, b_d, c_d, d_d, e_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [31:0] t_sum;

  assign t_sum = {a_q[26:0], a_q[31:27]} + sha1bs_pkg::round_f(rnd_q, b_q, c_q, d_q)
               + e_q + sha1bs_pkg::round_k(rnd_q) + w_i;

  assign done_o  = ctrl_i.step && (rnd_q == sha1bs_pkg::RoundLast);
  assign chain_o = chain_q;

  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    e_d     = e_q;
    rnd_d   = rnd_q;
    chain_d = chain_q;
    if (ctrl_i.start) begin
      a_d   = chain_q[0];
      b_d   = chain_q[1];
      c_d   = chain_q[2];
      d_d   = chain_q[3];
      e_d   = chain_q[4];
      rnd_d = '0;
    end else if (ctrl_i.step) begin
      a_d   = t_sum;
      b_d   = a_q;
      c_d   = {b_q[1:0], b_q[31:2]};
      d_d   = c_q;
      e_d   = d_q;
      rnd_d = rnd_q + 7'd1;
    end
    if (ctrl_i.init) begin
      chain_d = sha1bs_pkg::InitValue;
    end else if (ctrl_i.add) begin
      chain_d[0] = chain_q[0] + a_q;
      chain_d[1] = chain_q[1] + b_q;
      chain_d[2] = chain_q[2] + c_q;
      chain_d[3] = chain_q[3] + d_q;
      chain_d[4] = chain_q[4] + e_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= sha1bs_pkg::InitValue;
      rnd_q   <= '0;
    end else begin
      chain_q <= chain_d;
      rnd_q   <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
    e_q <= e_d;
  end

endmodule

>>> design/sha1_byte_stream_hasher_core.sv
// Top level of the SHA-1 byte stream hasher: sequencer, padding and digest output.
//
// Usage: each input beat carries an optional message byte (byte_valid_i) and an
// optional end-of-message mark (last_of_message_i). A plain byte beat is taken
// straight away while idle. Every 64th byte starts the compression: 80 rounds on
// the shared round unit, one round per cycle, then a fold of the result into the
// chaining value, so in_ready_o stays low through the rounds and the fold.
// A beat with the end mark appends 0x80, zero padding and the 64-bit bit length
// one byte per cycle into the block buffer, pausing for each compression and for
// the switch from padding to length; it compresses once or twice, then presents
// the digest as five output beats, most significant word first, with last_word_o
// on the fifth.
// While the output beats wait, no input is taken; a stalled receiver simply holds
// the current digest word. After the fifth word is accepted the block returns to
// its initial state and accepts the next message in the following cycle.
// Reset (rst_ni low) loads the initial chaining value and clears all counters.
module sha1_byte_stream_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha1bs_pkg::state_e     state_q, state_d;
  sha1bs_pkg::state_e     after_q, after_d;   // where to go once the block is folded in
  logic [5:0]             fill_q, fill_d;
  logic [63:0]            cnt_q, cnt_d;       // message byte count, wraps
  logic                   pad_first_q, pad_first_d;
  logic [2:0]             idx_q, idx_d;

  sha1bs_pkg::core_ctrl_t ctrl;
  logic                   shift_en;
  logic [7:0]             shift_byte;
  logic [31:0]            w_cur;
  logic                   round_done;
  logic [sha1bs_pkg::Words-1:0][31:0] chain;
  logic [63:0]            len_bits;

  assign len_bits = {cnt_q[60:0], 3'b000};

  sha1bs_sched u_sched (
    .clk_i       (clk_i),
    .shift_en_i  (shift_en),
    .shift_byte_i(shift_byte),
    .advance_i   (ctrl.step),
    .w_o         (w_cur)
  );

  sha1bs_core_unit u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .w_i    (w_cur),
    .done_o (round_done),
    .chain_o(chain)
  );

  assign digest_word_o = chain[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == sha1bs_pkg::WordLast);

  always_comb begin
    state_d     = state_q;
    after_d     = after_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    pad_first_d = pad_first_q;
    idx_d       = idx_q;
    ctrl        = '0;
    shift_en    = 1'b0;
    shift_byte  = data_byte_i;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    unique case (state_q)
      sha1bs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (byte_valid_i) begin
            // Absorb the byte; the end mark is handled after it.
            shift_en = 1'b1;
            fill_d   = fill_q + 6'd1;
            cnt_d    = cnt_q + 64'd1;
          end
          if (last_of_message_i) begin
            pad_first_d = 1'b1;
          end
          if (byte_valid_i && (fill_q == sha1bs_pkg::FillLast)) begin
            ctrl.start = 1'b1;
            state_d    = sha1bs_pkg::ST_COMP;
            after_d    = last_of_message_i ? sha1bs_pkg::ST_PAD : sha1bs_pkg::ST_IDLE;
          end else if (last_of_message_i) begin
            state_d = sha1bs_pkg::ST_PAD;
          end
        end
      end

      sha1bs_pkg::ST_PAD: begin
        if (!pad_first_q && (fill_q == sha1bs_pkg::LenPos)) begin
          state_d = sha1bs_pkg::ST_LEN;
        end else begin
          // Append the end marker first, then zeros.
          shift_en    = 1'b1;
          shift_byte  = pad_first_q ? sha1bs_pkg::PadByte : 8'h00;
          pad_first_d = 1'b0;
          fill_d      = fill_q + 6'd1;
          if (fill_q == sha1bs_pkg::FillLast) begin
            ctrl.start = 1'b1;
            state_d    = sha1bs_pkg::ST_COMP;
            after_d    = sha1bs_pkg::ST_PAD;
          end
        end
      end

      sha1bs_pkg::ST_LEN: begin
        // Positions 56..63 take the bit length, most significant byte first.
        shift_en   = 1'b1;
        shift_byte = len_bits[{~fill_q[2:0], 3'b000} +: 8];
        fill_d     = fill_q + 6'd1;
        if (fill_q == sha1bs_pkg::FillLast) begin
          ctrl.start = 1'b1;
          state_d    = sha1bs_pkg::ST_COMP;
          after_d    = sha1bs_pkg::ST_OUT;
        end
      end

      sha1bs_pkg::ST_COMP: begin
        ctrl.step = 1'b1;
        if (round_done) begin
          state_d = sha1bs_pkg::ST_ADD;
        end
      end

      sha1bs_pkg::ST_ADD: begin
        ctrl.add = 1'b1;
        state_d  = after_q;
      end

      sha1bs_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (idx_q == sha1bs_pkg::WordLast) begin
            // Digest delivered: re-initialize for the next message.
            idx_d     = '0;
            ctrl.init = 1'b1;
            cnt_d     = '0;
            fill_d    = '0;
            state_d   = sha1bs_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end

      default: begin
        state_d = sha1bs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha1bs_pkg::ST_IDLE;
      after_q     <= sha1bs_pkg::ST_IDLE;
      fill_q      <= '0;
      cnt_q       <= '0;
      pad_first_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      after_q     <= after_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      pad_first_q <= pad_first_d;
      idx_q       <= idx_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while digest is pending");

  a_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o) |=> (in_ready_o && fill_q == '0
      && cnt_q == '0))
    else $error("block not re-initialized after final digest word");

  a_comp_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1bs_pkg::ST_COMP) |-> (fill_q == '0))
    else $error("buffer fill nonzero during compression");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (word_index_o <= sha1bs_pkg::WordLast))
    else $error("digest word index out of range");

  a_len_after_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1bs_pkg::ST_LEN) |-> (!pad_first_q && fill_q >= sha1bs_pkg::LenPos))
    else $error("length field written before padding completed");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the SHA-1 byte stream hasher core.
module tb_top;

  localparam int ClkPeriod   = 4;
  localparam int ResetCycles = 3;
  localparam int DigestWords = 5;
  localparam int RandBeats   = 150;   // byte and end-mark beats of the random part
  localparam int DrainCycles = 300;   // covers the longest end-mark to digest latency
  localparam int QuietLimit  = 3000;  // cycles with no beat on either side
  localparam int MaxReports  = 20;

  typedef logic [0:DigestWords-1][31:0] digest_t;

  // One input beat plus the bench's own bookkeeping.
  typedef struct packed {
    logic [7:0] data;
    logic       byte_vld;
    logic       end_mark;
    logic       typed;       // digest below is the known answer for this message
    digest_t    typed_dig;
    logic       hold_after;  // hold the sender until every digest word is out
  } beat_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  localparam digest_t HashInit = {
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };
  localparam digest_t NoDigest    = '0;
  localparam digest_t EmptyDigest = {
    32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef, 32'h95601890, 32'hafd80709
  };
  localparam digest_t AbcDigest = {
    32'ha9993e36, 32'h4706816a, 32'hba3e2571, 32'h7850c26c, 32'h9cd0d89d
  };

  // Directed beats: data, byte valid, end mark, typed, typed digest, hold after.
  localparam int DirRows = 14;
  localparam beat_t DirTable [DirRows] = '{
    '{8'ha5, 1'b0, 1'b0, 1'b0, NoDigest,    1'b0},  // empty beat right after reset
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest, 1'b0},  // end mark alone: empty message
    '{8'h61, 1'b1, 1'b0, 1'b0, NoDigest,    1'b0},
    '{8'hff, 1'b0, 1'b0, 1'b0, NoDigest,    1'b0},  // empty beat inside a message
    '{8'h62, 1'b1, 1'b0, 1'b0, NoDigest,    1'b0},
    '{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest,   1'b0},  // byte and end mark together
    '{8'hff, 1'b0, 1'b1, 1'b1, EmptyDigest, 1'b0},  // state cleared after a digest
    '{8'h00, 1'b1, 1'b0, 1'b0, NoDigest,    1'b0},
    '{8'hff, 1'b1, 1'b0, 1'b0, NoDigest,    1'b0},
    '{8'h00, 1'b1, 1'b0, 1'b0, NoDigest,    1'b0},
    '{8'hff, 1'b1, 1'b0, 1'b0, NoDigest,    1'b0},
    '{8'hff, 1'b0, 1'b1, 1'b0, NoDigest,    1'b0},  // end mark after absorbed bytes
    '{8'hff, 1'b1, 1'b1, 1'b0, NoDigest,    1'b0},  // single all-ones byte
    '{8'h00, 1'b1, 1'b1, 1'b0, NoDigest,    1'b1}   // single zero byte, then drain
  };

  localparam int ForcedLens [2] = '{56, 64};
  localparam int EdgeLens [6]   = '{55, 56, 63, 64, 119, 120};

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i       = '0;
  logic        byte_valid_i      = 1'b0;
  logic        last_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i       = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  // Predictor state: chaining words, block buffer, fill level, message length.
  logic [31:0]  chain_h [DigestWords];
  logic [7:0]   blk_buf [64];
  int unsigned  blk_fill;
  logic [63:0]  msg_bytes;
  digest_beat_t digest_q [$];   // digest words still owed by the block

  int          errors        = 0;
  int          words_checked = 0;
  int          quiet_cycles  = 0;
  logic [31:0] cyc           = '0;

  sha1_byte_stream_hasher_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .byte_valid_i      (byte_valid_i),
    .last_of_message_i (last_of_message_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .digest_word_o     (digest_word_o),
    .word_index_o      (word_index_o),
    .last_word_o       (last_word_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MaxReports) begin
      $display("[%0t] %s: got %h, want %h", $time, what, got, want);
    end
  endtask

  function automatic void hash_restart();
    for (int i = 0; i < DigestWords; i++) begin
      chain_h[i] = HashInit[i];
    end
    blk_fill  = 0;
    msg_bytes = '0;
  endfunction

  // Run the 80 rounds over the buffered block and fold into the chaining words.
  function automatic void hash_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int r = 0; r < 16; r++) begin
      w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
    end
    for (int r = 16; r < 80; r++) begin
      x    = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {x[30:0], x[31]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5a827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ed9eba1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8f1bbcdc;
      end else begin
        f = b ^ c ^ d;
        k = 32'hca62c1d6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Absorb one accepted beat; on an end mark pad, finish and queue the digest.
  function automatic void hash_beat(input beat_t bt);
    logic [63:0] bit_len;
    digest_t     dig;
    if (bt.byte_vld) begin
      blk_buf[blk_fill] = bt.data;
      blk_fill++;
      msg_bytes++;
      if (blk_fill == 64) begin
        hash_compress();
        blk_fill = 0;
      end
    end
    if (!bt.end_mark) begin
      return;
    end
    bit_len = msg_bytes << 3;
    blk_buf[blk_fill] = 8'h80;
    blk_fill++;
    // No room left for the length field: close this block and start another.
    if (blk_fill > 56) begin
      for (int i = blk_fill; i < 64; i++) begin
        blk_buf[i] = 8'h00;
      end
      hash_compress();
      blk_fill = 0;
    end
    for (int i = blk_fill; i < 56; i++) begin
      blk_buf[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) begin
      blk_buf[63-i] = bit_len[8*i +: 8];
    end
    hash_compress();
    for (int i = 0; i < DigestWords; i++) begin
      dig[i] = chain_h[i];
    end
    // Known-answer rows owe the typed digest, not the computed one.
    if (bt.typed) begin
      dig = bt.typed_dig;
    end
    for (int i = 0; i < DigestWords; i++) begin
      digest_q.push_back('{dig[i], 3'(i), (i == DigestWords - 1)});
    end
    hash_restart();
  endfunction

  // Present one beat, hold it until taken, then advance the predictor.
  task automatic send_beat(input beat_t bt);
    in_valid_i        <= 1'b1;
    data_byte_i       <= bt.data;
    byte_valid_i      <= bt.byte_vld;
    last_of_message_i <= bt.end_mark;
    do @(posedge clk_i); while (!in_ready_o);
    hash_beat(bt);
  endtask

  // Receiver stall pattern: cycle through always ready, mostly ready,
  // one-in-four and coin-flip phases, stepped by bits 9:8 of the cycle counter.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    case (cyc[9:8])
      2'd0: begin
        out_ready_i <= 1'b1;
      end
      2'd1: begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
      2'd2: begin
        out_ready_i <= (cyc[1:0] == 2'd0);
      end
      default: begin
        out_ready_i <= 1'($urandom_range(0, 1));
      end
    endcase
  end

  // Check every digest beat against the oldest owed word.
  always @(posedge clk_i) begin : digest_check
    digest_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_checked++;
      if (digest_q.size() == 0) begin
        report_mismatch("digest beat with nothing owed", digest_word_o, '0);
      end else begin
        want = digest_q.pop_front();
        if (digest_word_o !== want.word) begin
          report_mismatch("digest_word", digest_word_o, want.word);
        end
        if (word_index_o !== want.idx) begin
          report_mismatch("word_index", 32'(word_index_o), 32'(want.idx));
        end
        if (last_word_o !== want.last) begin
          report_mismatch("last_word", 32'(last_word_o), 32'(want.last));
        end
      end
    end
  end

  // Drop the run if neither side moves a beat for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("[%0t] no beat for %0d cycles", $time, QuietLimit);
      $display("sha1_byte_stream_hasher_core regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    beat_t stim_q [$];
    beat_t bt;
    int    msg_len;
    int    rand_msgs;
    int    counted;
    int    ignored;
    int    burst_left;
    bit    split_end;

    hash_restart();
    foreach (DirTable[i]) begin
      stim_q.push_back(DirTable[i]);
    end

    // Random messages: the padding edge lengths first, then mostly short ones
    // with an occasional edge length. Sprinkle empty beats inside.
    rand_msgs = 0;
    counted   = 0;
    ignored   = 2;
    while (counted < RandBeats) begin
      if (rand_msgs < 2) begin
        msg_len = ForcedLens[rand_msgs];
      end else if ($urandom_range(0, 5) == 0) begin
        msg_len = EdgeLens[$urandom_range(0, 5)];
      end else begin
        msg_len = $urandom_range(0, 24);
      end
      split_end = (msg_len == 0) || ($urandom_range(0, 1) == 1);
      for (int j = 0; j < msg_len; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          bt      = '0;
          bt.data = 8'($urandom_range(0, 255));
          stim_q.push_back(bt);
          ignored++;
        end
        bt          = '0;
        bt.data     = 8'($urandom_range(0, 255));
        bt.byte_vld = 1'b1;
        bt.end_mark = !split_end && (j == msg_len - 1);
        stim_q.push_back(bt);
        counted++;
      end
      if (split_end) begin
        bt          = '0;
        bt.data     = 8'($urandom_range(0, 255));
        bt.end_mark = 1'b1;
        stim_q.push_back(bt);
        counted++;
      end
      if (rand_msgs == 2) begin
        stim_q[$].hold_after = 1'b1;
      end
      rand_msgs++;
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Send in bursts; hold the sender empty until the digests drain where marked.
    burst_left = 0;
    foreach (stim_q[n]) begin
      send_beat(stim_q[n]);
      if (stim_q[n].hold_after || n == stim_q.size() - 1) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (digest_q.size() != 0);
      end else if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end

    // Give a stray digest beat time to show up.
    repeat (DrainCycles) @(posedge clk_i);
    if (digest_q.size() != 0) begin
      report_mismatch("digest words never delivered", 32'(digest_q.size()), '0);
    end

    $display("Hashed %0d messages (%0d directed) from %0d beats, %0d of them empty.",
             DirRows > 0 ? rand_msgs + 6 : rand_msgs, 6, stim_q.size(), ignored);
    $display("Checked %0d digest words, incl. lengths 56 and 64 and known answers.",
             words_checked);
    if (errors == 0) begin
      $display("sha1_byte_stream_hasher_core regression: pass");
    end else begin
      $display("sha1_byte_stream_hasher_core regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sha1bs_pkg.sv
design/sha1bs_sched.sv
design/sha1bs_core_unit.sv
design/sha1_byte_stream_hasher_core.sv
bench/tb_top.sv
